/* hw/rtl/sats_pkg.sv */
// Shared types and constants of the array-held binary tree store.
`default_nettype none

package sats_pkg;

    // Widths of the transaction fields.
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned LOC_W    = 6;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FIDX_W   = 6;
    localparam int unsigned PIDX_W   = 5;

    // Action codes carried on the action port.
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_ROOT  = 2'd0,
        ACT_ADD_CHILD = 2'd1,
        ACT_DELETE    = 2'd2,
        ACT_SEARCH    = 2'd3
    } action_t;

    // Status codes reported with each result.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE        = 3'd0,
        STAT_ROOT_EXISTS = 3'd1,
        STAT_RANGE       = 3'd2,
        STAT_FOUND       = 3'd3,
        STAT_NOT_FOUND   = 3'd4
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/sequential_array_tree_store.sv */
// Top level of the array-held binary tree store with its sequencer and value memory.
//
// Usage: a transaction is accepted on the rising edge where start is high and
// busy is low; action, location, side and value are sampled at that edge.
// Each result appears on status, found_index, parent_index and last for exactly
// one cycle with strobe high; the receiver cannot stall, so it must take every
// result in the cycle in which it is shown.
// Sequencing:
//   Set root, add child, any out-of-range request and a delete of an entry with
//   no occupied child give their single result in the cycle after acceptance,
//   and the block is ready again in that cycle.
//   A delete that moves an entry walks the occupied marks down from NODES-1,
//   one entry a cycle, until it finds the highest occupied entry, then writes it.
//   A search reads one value memory entry a cycle through its single
//   registered read port; matches are reported in rising index order while
//   the scan runs, the final one marked by last.
// Reset clears all occupied marks at once; values are not cleared, and only
// the values of occupied entries are ever used.
`default_nettype none

module sequential_array_tree_store #(
    parameter int unsigned NODES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [sats_pkg::ACTION_W-1:0]        action,
    input  wire logic [sats_pkg::LOC_W-1:0]           location,
    input  wire logic                                 side,
    input  wire logic signed [sats_pkg::VALUE_W-1:0]  value,
    output logic                                      strobe,
    output logic [sats_pkg::STATUS_W-1:0]             status,
    output logic [sats_pkg::FIDX_W-1:0]               found_index,
    output logic [sats_pkg::PIDX_W-1:0]               parent_index,
    output logic                                      last
);

    localparam int unsigned IDX_W = $clog2(NODES);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam int unsigned EXT_W = sats_pkg::LOC_W + 1;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_DSCAN = 4'b1000
    } state_t;

    // Delete finds its source in DSCAN and writes it in the cycle after.
    typedef enum logic [1:0] {
        DEL_SEEK  = 2'b01,
        DEL_WRITE = 2'b10
    } del_phase_t;

    state_t                          state_reg, state_next;
    del_phase_t                      phase_reg, phase_next;
    logic [NODES-1:0]                occ_reg, occ_next;
    logic [sats_pkg::VALUE_W-1:0]    node_value_reg [NODES];
    logic [sats_pkg::VALUE_W-1:0]    rdata_reg;
    logic [sats_pkg::VALUE_W-1:0]    key_reg, key_next;
    logic [CNT_W-1:0]                rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]                cmp_idx_reg, cmp_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                pend_idx_reg, pend_idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]                src_reg, src_next;
    logic [IDX_W-1:0]                pos_reg, pos_next;

    logic                            strobe_reg, strobe_next;
    logic [sats_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [sats_pkg::FIDX_W-1:0]     fidx_reg, fidx_next;
    logic                            last_reg, last_next;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [sats_pkg::VALUE_W-1:0]    mem_wdata;
    logic [IDX_W-1:0]                mem_raddr;

    logic                            accept;
    logic [EXT_W-1:0]                loc_ext;
    logic [EXT_W-1:0]                child_l;
    logic [EXT_W-1:0]                child_r;
    logic                            child_l_full;
    logic                            child_r_full;
    logic                            hit;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign loc_ext = {1'b0, location};
    assign child_l = {location, 1'b0};
    assign child_r = {location, 1'b1};

    // Children at or beyond the end of the store count as empty.
    assign child_l_full = (child_l < EXT_W'(NODES)) && occ_reg[child_l[IDX_W-1:0]];
    assign child_r_full = (child_r < EXT_W'(NODES)) && occ_reg[child_r[IDX_W-1:0]];

    // Compare of the entry read in the previous search cycle.
    assign hit = cmp_valid_reg && occ_reg[cmp_idx_reg] && (rdata_reg == key_reg);

    // The search walks the read counter; everything else reads the delete source.
    assign mem_raddr = (state_reg == ST_SCAN) ? rd_cnt_reg[IDX_W-1:0] : src_reg;

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        occ_next        = occ_reg;
        key_next        = key_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        src_next        = src_reg;
        pos_next        = pos_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        fidx_next       = fidx_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (sats_pkg::action_t'(action))
                        sats_pkg::ACT_SET_ROOT:
                        begin
                            strobe_next = 1'b1;
                            fidx_next   = '0;
                            last_next   = 1'b1;
                            if (occ_reg[1])
                            begin
                                status_next = sats_pkg::STAT_ROOT_EXISTS;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = IDX_W'(1);
                                mem_wdata   = value;
                                occ_next[1] = 1'b1;
                                status_next = sats_pkg::STAT_DONE;
                            end
                        end
                        sats_pkg::ACT_ADD_CHILD:
                        begin
                            strobe_next = 1'b1;
                            fidx_next   = '0;
                            last_next   = 1'b1;
                            if ((location == '0) || ({location, side} >= EXT_W'(NODES)))
                            begin
                                status_next = sats_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'({location, side});
                                mem_wdata = value;
                                occ_next[IDX_W'({location, side})] = 1'b1;
                                status_next = sats_pkg::STAT_DONE;
                            end
                        end
                        sats_pkg::ACT_DELETE:
                        begin
                            if ((location == '0) || (loc_ext >= EXT_W'(NODES)))
                            begin
                                strobe_next = 1'b1;
                                status_next = sats_pkg::STAT_RANGE;
                                fidx_next   = '0;
                                last_next   = 1'b1;
                            end
                            else if (!child_l_full && !child_r_full)
                            begin
                                occ_next[IDX_W'(location)] = 1'b0;
                                strobe_next = 1'b1;
                                status_next = sats_pkg::STAT_DONE;
                                fidx_next   = '0;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                pos_next   = IDX_W'(location);
                                src_next   = IDX_W'(NODES - 1);
                                phase_next = DEL_SEEK;
                                state_next = ST_DSCAN;
                            end
                        end
                        sats_pkg::ACT_SEARCH:
                        begin
                            key_next        = value;
                            rd_cnt_next     = CNT_W'(1);
                            cmp_valid_next  = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while comparing the previous one.
                if (rd_cnt_reg < CNT_W'(NODES))
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                // A new match releases the one held back, which is then not the last.
                if (hit)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        status_next = sats_pkg::STAT_FOUND;
                        fidx_next   = sats_pkg::FIDX_W'(pend_idx_reg);
                        last_next   = 1'b0;
                    end
                    pend_idx_next   = cmp_idx_reg;
                    pend_valid_next = 1'b1;
                end
                if (cmp_valid_reg && (cmp_idx_reg == IDX_W'(NODES - 1)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // Final result of a search: the held match, or not found.
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_valid_reg)
                begin
                    status_next = sats_pkg::STAT_FOUND;
                    fidx_next   = sats_pkg::FIDX_W'(pend_idx_reg);
                end
                else
                begin
                    status_next = sats_pkg::STAT_NOT_FOUND;
                    fidx_next   = '0;
                end
                state_next = ST_IDLE;
            end
            ST_DSCAN:
            begin
                unique case (phase_reg)
                    DEL_SEEK:
                    begin
                        // The source is read every cycle so its value is ready when found.
                        if (occ_reg[src_reg])
                        begin
                            phase_next = DEL_WRITE;
                        end
                        else
                        begin
                            src_next = src_reg - IDX_W'(1);
                        end
                    end
                    DEL_WRITE:
                    begin
                        mem_we            = 1'b1;
                        mem_waddr         = pos_reg;
                        mem_wdata         = rdata_reg;
                        occ_next[src_reg] = 1'b0;
                        occ_next[pos_reg] = 1'b1;
                        strobe_next       = 1'b1;
                        status_next       = sats_pkg::STAT_DONE;
                        fidx_next         = '0;
                        last_next         = 1'b1;
                        state_next        = ST_IDLE;
                    end
                    default:
                    begin
                        phase_next = DEL_SEEK;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and occupied marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= DEL_SEEK;
            occ_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            occ_reg        <= occ_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        rd_cnt_reg   <= rd_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        pend_idx_reg <= pend_idx_next;
        src_reg      <= src_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        fidx_reg     <= fidx_next;
        last_reg     <= last_next;
    end

    // Value memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_value_reg[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= node_value_reg[mem_raddr];
    end

    // Result ports.
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign found_index  = fidx_reg;
    assign parent_index = fidx_reg[sats_pkg::FIDX_W-1:1];
    assign last         = last_reg;

    // An idle block with no new transaction shows no result next cycle.
    idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !strobe)
        else $error("result strobe without a transaction");

    // Results other than the final one only come from a search still running.
    early_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final result after the block went idle");

    // A found result never points at the unused entry zero.
    found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == sats_pkg::STAT_FOUND)) |-> (found_index != '0))
        else $error("found result with index zero");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the array-held binary tree store.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned NODES       = 64;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = NODES + 8;
    localparam int unsigned POOL_SIZE   = 6;

    typedef enum int
    {
        GAPS_NONE,
        GAPS_SHORT,
        GAPS_LONG
    } gap_mode_t;

    typedef struct
    {
        sats_pkg::status_t           status;
        logic [sats_pkg::FIDX_W-1:0] found_index;
        logic [sats_pkg::PIDX_W-1:0] parent_index;
        logic                        last;
    } tree_result_t;

    // Clock, reset and ports of the block.
    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          start    = 1'b0;
    sats_pkg::action_t             action   = sats_pkg::ACT_SET_ROOT;
    logic [sats_pkg::LOC_W-1:0]    location = '0;
    logic                          side     = 1'b0;
    logic [sats_pkg::VALUE_W-1:0]  value    = '0;
    logic                          busy;
    logic                          strobe;
    logic [sats_pkg::STATUS_W-1:0] status;
    logic [sats_pkg::FIDX_W-1:0]   found_index;
    logic [sats_pkg::PIDX_W-1:0]   parent_index;
    logic                          last;

    // Shadow copy of the tree and the results it predicts.
    logic [sats_pkg::VALUE_W-1:0]  tree_value [NODES];
    bit                            tree_used [NODES];
    tree_result_t                  pending_results [$];
    tree_result_t                  oldest_result;

    int unsigned                   fail_count  = 0;
    int unsigned                   cycle_count = 0;
    gap_mode_t                     gap_mode    = GAPS_NONE;
    int unsigned                   burst_left  = 0;
    logic [sats_pkg::VALUE_W-1:0]  value_pool [POOL_SIZE];

    sequential_array_tree_store #(
        .NODES(NODES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .location(location),
        .side(side),
        .value(value),
        .strobe(strobe),
        .status(status),
        .found_index(found_index),
        .parent_index(parent_index),
        .last(last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue one predicted result; the parent follows from the index.
    function automatic void push_result(sats_pkg::status_t st, int unsigned idx, logic fin);
        tree_result_t r;
        r.status       = st;
        r.found_index  = sats_pkg::FIDX_W'(idx);
        r.parent_index = sats_pkg::PIDX_W'(idx >> 1);
        r.last         = fin;
        pending_results.push_back(r);
    endfunction

    // Entries at or beyond NODES never count as occupied.
    function automatic bit slot_filled(int unsigned i);
        if (i >= NODES)
            return 1'b0;
        return tree_used[i];
    endfunction

    // Apply one accepted transaction to the shadow tree and predict its results.
    function automatic void tree_apply(sats_pkg::action_t act,
                                       logic [sats_pkg::LOC_W-1:0] loc, logic sd,
                                       logic [sats_pkg::VALUE_W-1:0] val);
        int unsigned tgt;
        int unsigned src;
        int unsigned hits;
        case (act)
            sats_pkg::ACT_SET_ROOT:
            begin
                if (tree_used[1])
                begin
                    push_result(sats_pkg::STAT_ROOT_EXISTS, 0, 1'b1);
                end
                else
                begin
                    tree_value[1] = val;
                    tree_used[1]  = 1'b1;
                    push_result(sats_pkg::STAT_DONE, 0, 1'b1);
                end
            end
            sats_pkg::ACT_ADD_CHILD:
            begin
                tgt = 2 * int'(loc) + int'(sd);
                if (loc == 0 || tgt >= NODES)
                begin
                    push_result(sats_pkg::STAT_RANGE, 0, 1'b1);
                end
                else
                begin
                    tree_value[tgt] = val;
                    tree_used[tgt]  = 1'b1;
                    push_result(sats_pkg::STAT_DONE, 0, 1'b1);
                end
            end
            sats_pkg::ACT_DELETE:
            begin
                if (loc == 0 || loc >= NODES)
                begin
                    push_result(sats_pkg::STAT_RANGE, 0, 1'b1);
                end
                else
                begin
                    // A leaf is cleared; otherwise the highest entry moves in.
                    if (!slot_filled(2 * int'(loc)) && !slot_filled(2 * int'(loc) + 1))
                    begin
                        tree_used[loc] = 1'b0;
                    end
                    else
                    begin
                        src = 0;
                        for (int i = 1; i < NODES; i++)
                        begin
                            if (tree_used[i])
                                src = i;
                        end
                        tree_value[loc] = tree_value[src];
                        tree_used[loc]  = 1'b1;
                        tree_used[src]  = 1'b0;
                    end
                    push_result(sats_pkg::STAT_DONE, 0, 1'b1);
                end
            end
            default:
            begin
                hits = 0;
                for (int i = 1; i < NODES; i++)
                begin
                    if (tree_used[i] && tree_value[i] == val)
                    begin
                        push_result(sats_pkg::STAT_FOUND, i, 1'b0);
                        hits++;
                    end
                end
                if (hits == 0)
                    push_result(sats_pkg::STAT_NOT_FOUND, 0, 1'b1);
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // Send one transaction, wait for acceptance, then idle per the burst pattern.
    task automatic send_item(sats_pkg::action_t act, logic [sats_pkg::LOC_W-1:0] loc,
                             logic sd, logic [sats_pkg::VALUE_W-1:0] val);
        int unsigned gap;
        start    <= 1'b1;
        action   <= act;
        location <= loc;
        side     <= sd;
        value    <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        tree_apply(act, loc, sd, val);
        if (gap_mode != GAPS_NONE)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 8);
                if (gap_mode == GAPS_LONG && $urandom_range(0, 2) == 0)
                    gap = $urandom_range(6, NODES + 8);
                else
                    gap = $urandom_range(1, 5);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic stop_sending();
        start <= 1'b0;
    endtask

    // Pick a random occupied entry in 1..limit, or 0 when there is none.
    function automatic int unsigned pick_occupied(int unsigned limit);
        int unsigned hits;
        int unsigned k;
        hits = 0;
        for (int i = 1; i <= limit; i++)
        begin
            if (tree_used[i])
                hits++;
        end
        if (hits == 0)
            return 0;
        k = $urandom_range(1, hits);
        for (int i = 1; i <= limit; i++)
        begin
            if (tree_used[i])
            begin
                k--;
                if (k == 0)
                    return i;
            end
        end
        return 0;
    endfunction

    // Mostly values from the pool so that searches hit, sometimes any pattern.
    function automatic logic [sats_pkg::VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Empty the tree by deleting the highest occupied entry, always a leaf.
    task automatic clear_tree();
        for (int i = NODES - 1; i >= 1; i--)
        begin
            if (tree_used[i])
                send_item(sats_pkg::ACT_DELETE, sats_pkg::LOC_W'(i), 1'(($urandom)),
                          $urandom);
        end
    endtask

    // Range errors, root handling, overwrite, duplicates and both delete forms.
    task automatic test_edge_cases();
        gap_mode = GAPS_SHORT;
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'h0000_0000);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd0, 1'b0, 32'h1111_1111);
        send_item(sats_pkg::ACT_DELETE, 6'd0, 1'b1, 32'h0);
        send_item(sats_pkg::ACT_DELETE, 6'd63, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd32, 1'b0, 32'h2222_2222);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd63, 1'b1, 32'h3333_3333);
        send_item(sats_pkg::ACT_SET_ROOT, 6'd63, 1'b1, 32'h7FFF_FFFF);
        send_item(sats_pkg::ACT_SET_ROOT, 6'd0, 1'b0, 32'h0000_0000);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd1, 1'b0, 32'h8000_0000);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd1, 1'b1, 32'hFFFF_FFFF);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd2, 1'b0, 32'h8000_0000);
        // The parent of entry 63 is empty; the add still lands.
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd31, 1'b1, 32'h8000_0000);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'h8000_0000);
        send_item(sats_pkg::ACT_SEARCH, 6'd63, 1'b1, 32'h7FFF_FFFF);
        send_item(sats_pkg::ACT_ADD_CHILD, 6'd1, 1'b0, 32'h1234_5678);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'h8000_0000);
        // Root has children, so the highest entry moves into it.
        send_item(sats_pkg::ACT_DELETE, 6'd1, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'h8000_0000);
        send_item(sats_pkg::ACT_DELETE, 6'd4, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_DELETE, 6'd4, 1'b1, 32'h0);
        send_item(sats_pkg::ACT_DELETE, 6'd2, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'hFFFF_FFFF);
        send_item(sats_pkg::ACT_DELETE, 6'd1, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_DELETE, 6'd1, 1'b0, 32'h0);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, 32'h8000_0000);
        clear_tree();
    endtask

    // Fill every entry with one value so a search returns the most results.
    task automatic test_full_tree();
        logic [sats_pkg::VALUE_W-1:0] fill_value;
        gap_mode   = GAPS_SHORT;
        fill_value = $urandom;
        clear_tree();
        send_item(sats_pkg::ACT_SET_ROOT, 6'd0, 1'b0, fill_value);
        for (int p = 1; p < NODES / 2; p++)
        begin
            send_item(sats_pkg::ACT_ADD_CHILD, sats_pkg::LOC_W'(p), 1'b0, fill_value);
            send_item(sats_pkg::ACT_ADD_CHILD, sats_pkg::LOC_W'(p), 1'b1, fill_value);
        end
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, fill_value);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b0, ~fill_value);
        repeat (6) send_item(sats_pkg::ACT_DELETE, 6'd1, 1'b0, $urandom);
        send_item(sats_pkg::ACT_SEARCH, 6'd0, 1'b1, fill_value);
        clear_tree();
    endtask

    // Mostly well-formed operations on occupied entries, with some noise.
    task automatic test_random_traffic(gap_mode_t mode, int unsigned count);
        int unsigned                  pick;
        int unsigned                  par;
        sats_pkg::action_t            act;
        logic [sats_pkg::LOC_W-1:0]   loc;
        logic                         sd;
        logic [sats_pkg::VALUE_W-1:0] val;
        gap_mode      = mode;
        value_pool[0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
        value_pool[1] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        if (mode == GAPS_SHORT)
            clear_tree();
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            loc  = sats_pkg::LOC_W'($urandom_range(0, 63));
            sd   = 1'($urandom);
            val  = pick_value();
            if (pick < 8)
            begin
                act = sats_pkg::ACT_SET_ROOT;
            end
            else if (pick < 48)
            begin
                act = sats_pkg::ACT_ADD_CHILD;
                if ($urandom_range(0, 9) != 0)
                begin
                    par = pick_occupied(NODES / 2 - 1);
                    if (par != 0)
                        loc = sats_pkg::LOC_W'(par);
                end
            end
            else if (pick < 68)
            begin
                act = sats_pkg::ACT_DELETE;
                if ($urandom_range(0, 6) != 0)
                begin
                    par = pick_occupied(NODES - 1);
                    if (par != 0)
                        loc = sats_pkg::LOC_W'(par);
                end
            end
            else
            begin
                act = sats_pkg::ACT_SEARCH;
            end
            send_item(act, loc, sd, val);
        end
    endtask

    // Compare every result with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, found_index %0d, last %0d",
                       status, found_index, last);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_result.status, status);
                    fail_count++;
                end
                if (found_index !== oldest_result.found_index)
                begin
                    $error("found_index: expected %0d, actual %0d",
                           oldest_result.found_index, found_index);
                    fail_count++;
                end
                if (parent_index !== oldest_result.parent_index)
                begin
                    $error("parent_index: expected %0d, actual %0d",
                           oldest_result.parent_index, parent_index);
                    fail_count++;
                end
                if (last !== oldest_result.last)
                begin
                    $error("last: expected %0d, actual %0d", oldest_result.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_full_tree();
        test_random_traffic(GAPS_NONE, 70);
        test_random_traffic(GAPS_SHORT, 70);
        test_random_traffic(GAPS_LONG, 70);
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
